// ===== src/dks_pkg.sv =====
// ----------------------------------------------------------------------------
// dks_pkg: shared types and constants for the distance key sorter
// Field widths, controller command and status structs.
// ----------------------------------------------------------------------------
package dks_pkg;

	localparam int KeyW = 31;
	localparam int TagW = 16;
	localparam int DefMaxItems = 64;

	// controller -> datapath commands
	typedef struct packed {
		logic load;   // store the input item (if room)
		logic emit;   // pop the head item into the output register
		logic clear;  // start a new set
	} dks_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic empty;  // no stored items left
		logic one;    // exactly one stored item left
	} dks_sts_t;

endpackage

// ===== src/dks_datapath.sv =====
// ----------------------------------------------------------------------------
// dks_datapath: insertion cell chain
// Each cell holds a key and tag; a new item is inserted in key order
// (after all equal keys, for stability). Emission shifts the chain down.
// ----------------------------------------------------------------------------
module dks_datapath
	import dks_pkg::*;
#(
	parameter int MAX_ITEMS = DefMaxItems
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dks_cmd_t             cmd,
	output dks_sts_t             sts,
	input  logic [KeyW-1:0]      in_key,
	input  logic [TagW-1:0]      in_tag,
	output logic [KeyW-1:0]      head_key,
	output logic [TagW-1:0]      head_tag,
	output logic                 dropped
);

	localparam int CntW = $clog2(MAX_ITEMS + 1);

	logic [KeyW-1:0] key_q [MAX_ITEMS];
	logic [TagW-1:0] tag_q [MAX_ITEMS];
	logic [MAX_ITEMS-1:0] occ_q;
	logic [CntW-1:0] count_q;
	logic dropped_q;
	logic full;
	logic [MAX_ITEMS-1:0] gt;

	assign full = (count_q == CntW'(MAX_ITEMS));

	// per-cell compare: occupied cell with key strictly greater moves up
	always_comb begin
		for (int i = 0; i < MAX_ITEMS; i++) begin
			gt[i] = occ_q[i] && (key_q[i] > in_key);
		end
	end

	// cell array
	always_ff @(posedge clk) begin
		if (cmd.load && !full) begin
			for (int i = 0; i < MAX_ITEMS; i++) begin
				if (gt[i]) begin
					if (i > 0) begin
						if (!gt[i-1]) begin
							key_q[i] <= in_key;
							tag_q[i] <= in_tag;
						end else begin
							key_q[i] <= key_q[i-1];
							tag_q[i] <= tag_q[i-1];
						end
					end else begin
						key_q[i] <= in_key;
						tag_q[i] <= in_tag;
					end
				end else if (!occ_q[i] && (i == 0 || occ_q[i-1])) begin
					// first free cell: takes the shifted top item or the new one
					if (i > 0 && gt[i-1]) begin
						key_q[i] <= key_q[i-1];
						tag_q[i] <= tag_q[i-1];
					end else begin
						key_q[i] <= in_key;
						tag_q[i] <= in_tag;
					end
				end
			end
		end else if (cmd.emit) begin
			for (int i = 0; i < MAX_ITEMS - 1; i++) begin
				key_q[i] <= key_q[i+1];
				tag_q[i] <= tag_q[i+1];
			end
		end
	end

	// occupancy, count and drop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q     <= '0;
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else if (cmd.clear) begin
			occ_q     <= '0;
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else if (cmd.load) begin
			if (full) begin
				dropped_q <= 1'b1;
			end else begin
				occ_q   <= {occ_q[MAX_ITEMS-2:0], 1'b1};
				count_q <= count_q + 1'b1;
			end
		end else if (cmd.emit) begin
			occ_q   <= occ_q >> 1;
			count_q <= count_q - 1'b1;
		end
	end

	assign head_key  = key_q[0];
	assign head_tag  = tag_q[0];
	assign dropped   = dropped_q;
	assign sts.empty = !occ_q[0];
	assign sts.one   = occ_q[0] && (MAX_ITEMS < 2 || !occ_q[1]);

`ifndef SYNTH
	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(occ_q) == int'(count_q)) else $error("occupancy/count mismatch");
	a_occ_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((occ_q + 1'b1) & occ_q) == '0) else $error("occupancy not contiguous");
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q[1] |-> key_q[0] <= key_q[1]) else $error("head out of order");
`endif

endmodule

// ===== src/dks_ctrl.sv =====
// ----------------------------------------------------------------------------
// dks_ctrl: load/emit controller
// Accepts items in LOAD; after the last item drains the chain in EMIT.
// ----------------------------------------------------------------------------
module dks_ctrl
	import dks_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  logic     in_last,
	output logic     m_tvalid,
	input  logic     m_tready,
	output logic     out_last,
	output logic     out_overflow,
	output logic     out_load,      // capture head into output register
	input  logic     dropped,
	input  dks_sts_t sts,
	output dks_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_LOAD = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t state_q;
	logic vld_q, last_q, ovf_q;
	logic s_acc, slot_free, pop;

	assign s_tready  = (state_q == ST_LOAD);
	assign s_acc     = s_tvalid && s_tready;
	assign slot_free = !vld_q || m_tready;
	assign pop       = (state_q == ST_EMIT) && !sts.empty && slot_free;
	assign out_load  = pop;

	always_comb begin
		cmd.load  = s_acc;
		cmd.emit  = pop;
		cmd.clear = pop && sts.one;
	end

	// state and output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			vld_q   <= 1'b0;
			last_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			if (pop) begin
				vld_q  <= 1'b1;
				last_q <= sts.one;
				ovf_q  <= dropped;
			end else if (m_tready) begin
				vld_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: if (s_acc && in_last) state_q <= ST_EMIT;
				ST_EMIT: if (pop && sts.one) state_q <= ST_LOAD;
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign m_tvalid     = vld_q;
	assign out_last     = last_q;
	assign out_overflow = ovf_q;

`ifndef SYNTH
	a_no_load_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.emit)) else $error("load and emit together");
	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> !sts.empty) else $error("emit state with empty chain");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && sts.one) |=> state_q == ST_LOAD) else $error("set did not end");
`endif

endmodule

// ===== src/distance_key_sorter.sv =====
// ----------------------------------------------------------------------------
// distance_key_sorter: stable ascending sort of a set of keyed items
// Loads one item per cycle into an insertion cell chain, then emits the set.
// ----------------------------------------------------------------------------
// m_tvalid rises once the controller is in EMIT and the head is in the output register.
// Throughput: 1 item per cycle while loading, 1 result per cycle while emitting
//   while the receiver is ready; input is held off during the emit of a set.
// The insertion chain compare/shift sets the one-item-per-cycle load rate.
// Reset: arst_n clears occupancy, count, drop flag and the controller.
module distance_key_sorter
	import dks_pkg::*;
#(
	parameter int MAX_ITEMS = DefMaxItems
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [30:0] in_key, [46:31] in_tag, [47] zero
	input  logic        s_tlast,   // in_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [30:0] out_key, [46:31] out_tag, [47] zero
	output logic        m_tlast,   // out_last
	output logic        m_tuser    // out_overflow
);

	dks_cmd_t cmd;
	dks_sts_t sts;
	logic [KeyW-1:0] head_key;
	logic [TagW-1:0] head_tag;
	logic dropped, out_load;
	logic [KeyW-1:0] key_q;
	logic [TagW-1:0] tag_q;

	dks_datapath #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.in_key(s_tdata[30:0]), .in_tag(s_tdata[46:31]),
		.head_key, .head_tag, .dropped
	);

	dks_ctrl u_ctrl (
		.clk, .arst_n, .s_tvalid, .s_tready, .in_last(s_tlast),
		.m_tvalid, .m_tready, .out_last(m_tlast), .out_overflow(m_tuser),
		.out_load, .dropped, .sts, .cmd
	);

	// output payload register
	always_ff @(posedge clk) begin
		if (out_load) begin
			key_q <= head_key;
			tag_q <= head_tag;
		end
	end

	assign m_tdata = {1'b0, tag_q, key_q};

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the distance key sorter
// Streams sets of keyed items into the block and checks that every set comes
// back in stable ascending key order, with the last mark on the final item and
// the overflow flag on every item of a set that ran past the store capacity.
// ----------------------------------------------------------------------------

// Tracks the store contents and keeps the sorted results still to come
class sort_scoreboard;
	localparam int Cap = dks_pkg::DefMaxItems;

	typedef struct packed {
		logic [dks_pkg::KeyW-1:0] key;
		logic [dks_pkg::TagW-1:0] tag;
		logic                     last;
		logic                     ovf;
	} sorted_item_t;

	logic [dks_pkg::KeyW-1:0] keys[$];
	logic [dks_pkg::TagW-1:0] tags[$];
	logic                     dropped;
	sorted_item_t             pending[$];
	int                       errors;
	int                       results;
	int                       sets;
	int                       overflow_sets;

	function new();
		dropped = 0;
		errors = 0;
		results = 0;
		sets = 0;
		overflow_sets = 0;
	endfunction

	// Note one accepted input transaction; on the last item, sort the set
	function void note_input(logic [dks_pkg::KeyW-1:0] key, logic [dks_pkg::TagW-1:0] tag,
			logic last);
		sorted_item_t it;
		int n;
		int j;
		logic [dks_pkg::KeyW-1:0] k;
		logic [dks_pkg::TagW-1:0] t;
		if (keys.size() < Cap) begin
			keys.push_back(key);
			tags.push_back(tag);
		end else begin
			dropped = 1;
		end
		if (!last)
			return;
		n = keys.size();
		// stable insertion sort
		for (int i = 1; i < n; i++) begin
			k = keys[i];
			t = tags[i];
			j = i;
			while (j > 0 && keys[j-1] > k) begin
				keys[j] = keys[j-1];
				tags[j] = tags[j-1];
				j--;
			end
			keys[j] = k;
			tags[j] = t;
		end
		for (int i = 0; i < n; i++) begin
			it.key = keys[i];
			it.tag = tags[i];
			it.last = (i == n - 1);
			it.ovf = dropped;
			pending.push_back(it);
		end
		sets++;
		if (dropped)
			overflow_sets++;
		keys.delete();
		tags.delete();
		dropped = 0;
	endfunction

	task report(string what, logic [31:0] got, logic [31:0] want);
		$display("ERROR at %0t: result %0d %s got 0x%0h want 0x%0h", $time, results, what,
			got, want);
		errors++;
	endtask

	// Check one accepted output transaction against the oldest expectation
	task check_result(logic [47:0] data, logic last, logic ovf);
		sorted_item_t w;
		if (pending.size() == 0) begin
			report("unexpected key", 32'(data[30:0]), 32'd0);
			return;
		end
		w = pending.pop_front();
		if (data[30:0] != w.key)
			report("key", 32'(data[30:0]), 32'(w.key));
		if (data[46:31] != w.tag)
			report("tag", 32'(data[46:31]), 32'(w.tag));
		if (data[47] != 1'b0)
			report("pad bit", 32'(data[47]), 32'd0);
		if (last != w.last)
			report("last", 32'(last), 32'(w.last));
		if (ovf != w.ovf)
			report("overflow", 32'(ovf), 32'(w.ovf));
		results++;
	endtask
endclass

module tb_top;
	import dks_pkg::*;

	localparam int StallLimit = 5000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	sort_scoreboard sb;
	int  send_idle_pct;
	int  recv_idle_pct;
	bit  hold_off;
	int  quiet_cycles;
	int  items_sent;

	distance_key_sorter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Scoreboard sampling at each edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_input(s_tdata[30:0], s_tdata[46:31], s_tlast);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tlast, m_tuser);
		end
	end

	// Watchdog: cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("timeout: no transaction for %0d cycles", StallLimit);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver backpressure
	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
	end

	// Offer one item, with random idle cycles before it
	task automatic send_item(logic [KeyW-1:0] key, logic [TagW-1:0] tag, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, tag, key};
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
	endtask

	// Random key: mostly narrow values so equal keys occur, sometimes full range
	function automatic logic [KeyW-1:0] rand_key();
		case ($urandom_range(3))
			0: rand_key = KeyW'($urandom_range(7));
			1: rand_key = KeyW'($urandom);
			2: rand_key = 31'h7FFF_FFFF - KeyW'($urandom_range(3));
			default: rand_key = KeyW'($urandom_range(1000));
		endcase
	endfunction

	task automatic send_set(int n);
		for (int i = 0; i < n; i++)
			send_item(rand_key(), TagW'($urandom), i == n - 1);
	endtask

	// Long receiver hold-off while the sender keeps offering the oversized overflow set
	initial begin
		hold_off = 0;
		wait (items_sent > 40);
		hold_off = 1;
		repeat (300) @(posedge clk);
		hold_off = 0;
	end

	initial begin
		sb = new();
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tlast = 0;
		quiet_cycles = 0;
		items_sent = 0;
		send_idle_pct = 36;
		recv_idle_pct = 51;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: single item sets, extremes, equal keys, reverse order
		send_item(31'h7FFF_FFFF, 16'hFFFF, 1);
		send_item(31'h0, 16'h0, 1);
		send_item(31'h7FFF_FFFF, 16'h0001, 0);
		send_item(31'h0, 16'hFFFF, 0);
		send_item(31'h5555_5555, 16'hAAAA, 0);
		send_item(31'h2AAA_AAAA, 16'h5555, 1);
		for (int i = 0; i < 6; i++)
			send_item(31'd42, TagW'(i), i == 5);
		for (int i = 0; i < 6; i++)
			send_item(KeyW'(6 - i), 16'h100 + TagW'(i), i == 5);

		// Overflow: one set past capacity, items beyond the 64th dropped
		for (int i = 0; i < 70; i++)
			send_item(rand_key(), TagW'(i), i == 69);

		// Random sets through three idling phases
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 51 : 0;
			recv_idle_pct = (ph == 0) ? 51 : (ph == 1) ? 36 : 0;
			for (int s = 0; s < 6; s++)
				send_set($urandom_range(1, 8));
			if (ph == 1)
				send_set(64);
		end
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Ran %0d items in %0d sets (%0d overflowed), %0d sorted results checked.",
			items_sent, sb.sets, sb.overflow_sets, sb.results);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
